[sv/lfos_pkg.sv]
// ----------------------------------------------------------------------------
// Line follow and obstacle steering package
// Shared widths, codes, register indexes, reset values and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfos_pkg;

   localparam int SENSOR_COUNT_DEF     = 8;
   localparam int MAX_TRACK_ACTIVE_DEF = 5;

   localparam int LINE_W     = 8;
   localparam int DIST_W     = 16;
   localparam int SPEED_W    = 7;
   localparam int GAIN_W     = 4;
   localparam int OUT_W      = 8;
   localparam int MODE_W     = 3;
   localparam int ERR_W      = 7;
   localparam int SUM_W      = 11;
   localparam int WGT_W      = 8;
   localparam int LIT_W      = 5;
   localparam int SPD_W      = 10;
   localparam int DIV_NUM_W  = 11;
   localparam int DIV_DEN_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int WEIGHT_STEP  = 10;
   localparam int WEIGHT_HALF  = 5;
   localparam int TURN_DIVISOR = 10;

   // Division by ten as a multiply by ceil(2^19 / 10) and a shift by 19.
   localparam int TURN_RECIP       = 52429;
   localparam int TURN_RECIP_W     = 16;
   localparam int TURN_RECIP_SHIFT = 19;

   localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TRACK      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CROSS      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOST       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EVADE_RIGHT = 3'd4;
   localparam logic [MODE_W-1:0] MODE_EVADE_LEFT = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_SAFE_DISTANCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVALID_DISTANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_GAIN        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PIVOT_SPEED      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EVADE_SPEED      = 3'd5;

   localparam logic [DIST_W-1:0]  RST_SAFE_DISTANCE    = 16'd22;
   localparam logic [DIST_W-1:0]  RST_INVALID_DISTANCE = 16'd65535;
   localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED     = 7'd22;
   localparam logic [GAIN_W-1:0]  RST_TURN_GAIN        = 4'd4;
   localparam logic [SPEED_W-1:0] RST_PIVOT_SPEED      = 7'd18;
   localparam logic [SPEED_W-1:0] RST_EVADE_SPEED      = 7'd25;

   typedef struct packed {
      logic              motors_enabled;
      logic [LINE_W-1:0] line_bits;
      logic [DIST_W-1:0] front_cm;
      logic [DIST_W-1:0] left_cm;
      logic [DIST_W-1:0] right_cm;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] left_speed;
      logic signed [OUT_W-1:0] right_speed;
      logic [MODE_W-1:0]       mode;
   } rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0]  safe_distance;
      logic [DIST_W-1:0]  invalid_distance;
      logic [SPEED_W-1:0] cruise_speed;
      logic [GAIN_W-1:0]  turn_gain;
      logic [SPEED_W-1:0] pivot_speed;
      logic [SPEED_W-1:0] evade_speed;
   } cfg_type;

endpackage

`default_nettype wire

[sv/line_follow_obstacle_steering.sv]
// ----------------------------------------------------------------------------
// Line follow and obstacle steering controller
// Turns one control tick into a differential wheel speed pair and a mode.
// ----------------------------------------------------------------------------
// Idle, evade, lost-line and crossing transactions give their result in the cycle
// after acceptance. A tracking transaction runs a sensor scan of one sensor per
// cycle, an 11-step centroid divide, a gain multiply and a reciprocal scaling
// by ten. One transaction is in work at a time.
// Reset clears the sequencer, the output valid and the stored line error, and
// loads the register defaults.
`default_nettype none

module line_follow_obstacle_steering #(
   parameter int SENSOR_COUNT     = lfos_pkg::SENSOR_COUNT_DEF,
   parameter int MAX_TRACK_ACTIVE = lfos_pkg::MAX_TRACK_ACTIVE_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire lfos_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output lfos_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [lfos_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [lfos_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LINE_W    = lfos_pkg::LINE_W;
   localparam int OUT_W     = lfos_pkg::OUT_W;
   localparam int ERR_W     = lfos_pkg::ERR_W;
   localparam int SUM_W     = lfos_pkg::SUM_W;
   localparam int WGT_W     = lfos_pkg::WGT_W;
   localparam int LIT_W     = lfos_pkg::LIT_W;
   localparam int SPD_W     = lfos_pkg::SPD_W;
   localparam int NUM_W     = lfos_pkg::DIV_NUM_W;
   localparam int DEN_W     = lfos_pkg::DIV_DEN_W;
   localparam int SCL_W     = lfos_pkg::DIV_NUM_W + lfos_pkg::TURN_RECIP_W;
   localparam int IDX_W     = $clog2(SENSOR_COUNT);
   localparam int SCAN_BITS = (SENSOR_COUNT < LINE_W) ? SENSOR_COUNT : LINE_W;
   localparam int WGT_START_I = -(lfos_pkg::WEIGHT_HALF * (SENSOR_COUNT - 1));
   localparam logic signed [WGT_W-1:0] WGT_START = WGT_W'(WGT_START_I);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SCAN      = 7'b0000010,
      ST_DIV1_GO   = 7'b0000100,
      ST_DIV1_WAIT = 7'b0001000,
      ST_MUL       = 7'b0010000,
      ST_SCALE     = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SPD_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SPD_W'(127)) begin
         r = OUT_W'(127);
      end else if (v < -SPD_W'(128)) begin
         r = OUT_W'(-128);
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   lfos_pkg::cfg_type cfg;

   state_type                 state_ff, state_in;
   logic [LINE_W-1:0]         bits_ff, bits_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [WGT_W-1:0]   wgt_ff, wgt_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [LIT_W-1:0]          lit_ff, lit_in;
   logic                      neg_ff, neg_in;
   logic [ERR_W-1:0]          errmag_ff, errmag_in;
   logic [NUM_W-1:0]          prod_ff, prod_in;
   logic [ERR_W-1:0]          turnmag_ff, turnmag_in;
   logic signed [ERR_W-1:0]   last_error_ff, last_error_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lfos_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                      req_accept;
   logic                      rsp_free;
   logic                      front_clear;
   logic [LIT_W-1:0]          lit_cnt;
   logic signed [OUT_W-1:0]   evade_pos, spin_pos, base_pos;
   logic                      last_positive;
   lfos_pkg::rsp_type         imm_rsp;
   logic                      imm_done;
   logic [SUM_W-1:0]          abs_sum;
   logic [NUM_W-1:0]          prod;
   logic [SCL_W-1:0]          scaled;
   logic signed [SPD_W-1:0]   base_s, turn_s, left_w, right_w;
   logic signed [ERR_W:0]     err_w;
   logic signed [ERR_W-1:0]   err_sat;

   logic                      div_start;
   logic [NUM_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic                      div_done;
   logic [NUM_W-1:0]          div_quo;

   lfos_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && rsp_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      lit_cnt = '0;
      for (int i = 0; i < LINE_W; i++) begin
         if (i < SCAN_BITS) begin
            lit_cnt = lit_cnt + LIT_W'(req_data.line_bits[i]);
         end
      end
   end

   always_comb begin
      front_clear   = (req_data.front_cm >= cfg.safe_distance) ||
                      (req_data.front_cm == cfg.invalid_distance);
      evade_pos     = OUT_W'(cfg.evade_speed);
      spin_pos      = OUT_W'(cfg.pivot_speed);
      base_pos      = OUT_W'(cfg.cruise_speed);
      last_positive = !last_error_ff[ERR_W-1] && (last_error_ff != '0);
      imm_done      = 1'b1;
      imm_rsp.left_speed  = '0;
      imm_rsp.right_speed = '0;
      imm_rsp.mode        = lfos_pkg::MODE_IDLE;
      if (!req_data.motors_enabled) begin
         imm_rsp.mode = lfos_pkg::MODE_IDLE;
      end else if (!front_clear) begin
         if (req_data.left_cm < req_data.right_cm) begin
            imm_rsp.left_speed  = evade_pos;
            imm_rsp.right_speed = -evade_pos;
            imm_rsp.mode        = lfos_pkg::MODE_EVADE_RIGHT;
         end else begin
            imm_rsp.left_speed  = -evade_pos;
            imm_rsp.right_speed = evade_pos;
            imm_rsp.mode        = lfos_pkg::MODE_EVADE_LEFT;
         end
      end else if (lit_cnt == '0) begin
         imm_rsp.left_speed  = last_positive ? spin_pos : -spin_pos;
         imm_rsp.right_speed = last_positive ? -spin_pos : spin_pos;
         imm_rsp.mode        = lfos_pkg::MODE_LOST;
      end else if (lit_cnt > LIT_W'(MAX_TRACK_ACTIVE)) begin
         imm_rsp.left_speed  = base_pos;
         imm_rsp.right_speed = base_pos;
         imm_rsp.mode        = lfos_pkg::MODE_CROSS;
      end else begin
         imm_done = 1'b0;
      end
   end

   always_comb begin
      abs_sum = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
      prod    = NUM_W'(errmag_ff) * NUM_W'(cfg.turn_gain);
      scaled  = SCL_W'(prod_ff) * SCL_W'(lfos_pkg::TURN_RECIP);
      base_s  = SPD_W'(cfg.cruise_speed);
      turn_s  = neg_ff ? -SPD_W'(turnmag_ff) : SPD_W'(turnmag_ff);
      left_w  = base_s + turn_s;
      right_w = base_s - turn_s;
      err_w   = neg_ff ? -{1'b0, errmag_ff} : {1'b0, errmag_ff};
      if (err_w > (ERR_W + 1)'(63)) begin
         err_sat = ERR_W'(63);
      end else if (err_w < -(ERR_W + 1)'(64)) begin
         err_sat = ERR_W'(-64);
      end else begin
         err_sat = err_w[ERR_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      bits_in       = bits_ff;
      idx_in        = idx_ff;
      wgt_in        = wgt_ff;
      sum_in        = sum_ff;
      lit_in        = lit_ff;
      neg_in        = neg_ff;
      errmag_in     = errmag_ff;
      prod_in       = prod_ff;
      turnmag_in    = turnmag_ff;
      last_error_in = last_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_num       = NUM_W'(abs_sum);
      div_den       = DEN_W'(lit_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (imm_done) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = imm_rsp;
               end else begin
                  state_in = ST_SCAN;
                  bits_in  = req_data.line_bits;
                  idx_in   = '0;
                  wgt_in   = WGT_START;
                  sum_in   = '0;
                  lit_in   = lit_cnt;
               end
            end
         end
         ST_SCAN: begin
            if (bits_ff[0]) begin
               sum_in = sum_ff + SUM_W'(wgt_ff);
            end
            wgt_in  = wgt_ff + WGT_W'(lfos_pkg::WEIGHT_STEP);
            bits_in = bits_ff >> 1;
            idx_in  = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(SENSOR_COUNT - 1)) begin
               state_in = ST_DIV1_GO;
            end
         end
         ST_DIV1_GO: begin
            div_start = 1'b1;
            neg_in    = sum_ff[SUM_W-1];
            state_in  = ST_DIV1_WAIT;
         end
         ST_DIV1_WAIT: begin
            if (div_done) begin
               errmag_in = div_quo[ERR_W-1:0];
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            turnmag_in = scaled[lfos_pkg::TURN_RECIP_SHIFT +: ERR_W];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.left_speed  = sat_out(left_w);
               rsp_data_in.right_speed = sat_out(right_w);
               rsp_data_in.mode        = lfos_pkg::MODE_TRACK;
               last_error_in           = err_sat;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_error_ff <= last_error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bits_ff     <= bits_in;
      idx_ff      <= idx_in;
      wgt_ff      <= wgt_in;
      sum_ff      <= sum_in;
      lit_ff      <= lit_in;
      neg_ff      <= neg_in;
      errmag_ff   <= errmag_in;
      prod_ff     <= prod_in;
      turnmag_ff  <= turnmag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_disabled_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_data.motors_enabled) |=>
      (rsp_valid && rsp_data.mode == lfos_pkg::MODE_IDLE))
      else $error("Disabled transaction did not give an idle result.");

   a_last_error_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |=> $stable(last_error_ff))
      else $error("Stored line error changed outside a tracking result.");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV1_WAIT))
      else $error("Divider finished while the sequencer was not waiting.");

   a_track_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=>
      (rsp_valid && rsp_data.mode == lfos_pkg::MODE_TRACK && state_ff == ST_IDLE))
      else $error("Tracking result was not issued.");

endmodule

`default_nettype wire

[sv/lfos_regs.sv]
// ----------------------------------------------------------------------------
// Steering configuration registers
// Holds the six control registers written through the register port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfos_regs (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write,
   input  wire [lfos_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [lfos_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output lfos_pkg::cfg_type                      cfg
);

   lfos_pkg::cfg_type cfg_ff;
   lfos_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            lfos_pkg::REG_SAFE_DISTANCE: begin
               cfg_in.safe_distance = csr_wdata[lfos_pkg::DIST_W-1:0];
            end
            lfos_pkg::REG_INVALID_DISTANCE: begin
               cfg_in.invalid_distance = csr_wdata[lfos_pkg::DIST_W-1:0];
            end
            lfos_pkg::REG_CRUISE_SPEED: begin
               cfg_in.cruise_speed = csr_wdata[lfos_pkg::SPEED_W-1:0];
            end
            lfos_pkg::REG_TURN_GAIN: begin
               cfg_in.turn_gain = csr_wdata[lfos_pkg::GAIN_W-1:0];
            end
            lfos_pkg::REG_PIVOT_SPEED: begin
               cfg_in.pivot_speed = csr_wdata[lfos_pkg::SPEED_W-1:0];
            end
            lfos_pkg::REG_EVADE_SPEED: begin
               cfg_in.evade_speed = csr_wdata[lfos_pkg::SPEED_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.safe_distance    <= lfos_pkg::RST_SAFE_DISTANCE;
         cfg_ff.invalid_distance <= lfos_pkg::RST_INVALID_DISTANCE;
         cfg_ff.cruise_speed     <= lfos_pkg::RST_CRUISE_SPEED;
         cfg_ff.turn_gain        <= lfos_pkg::RST_TURN_GAIN;
         cfg_ff.pivot_speed      <= lfos_pkg::RST_PIVOT_SPEED;
         cfg_ff.evade_speed      <= lfos_pkg::RST_EVADE_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/lfos_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle, used for the centroid division
// by the lit sensor count.
// ----------------------------------------------------------------------------
`default_nettype none

module lfos_div (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire [lfos_pkg::DIV_NUM_W-1:0]       num,
   input  wire [lfos_pkg::DIV_DEN_W-1:0]       den,
   output logic                                done,
   output logic [lfos_pkg::DIV_NUM_W-1:0]      quotient
);

   localparam int NUM_W = lfos_pkg::DIV_NUM_W;
   localparam int DEN_W = lfos_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
